// ----- rtl/sucs_pkg.sv -----
// shared types, widths, register codes and fixed-point helpers for the
// stereo utility channel strip; no dependencies
package sucs_pkg;

  // sample widths: io, internal, filter output, crossover state
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned IW = SAMPLE_W + 4;
  localparam int unsigned LW = IW + 4;
  localparam int unsigned ZW = IW + 12;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_AW = LW;
  localparam int unsigned MUL_BW = 33;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  // dc blocker pole, Q0.23
  localparam int DC_POLE = 8383117;

  // wide signed type for intermediate arithmetic
  localparam int unsigned WIDE_W = MUL_PW + 1;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CONTROL,
    REG_GAIN,
    REG_BAL_L,
    REG_BAL_R,
    REG_WIDTH,
    REG_LP_B0,
    REG_LP_A1,
    REG_LP_A2
  } reg_idx_t;

  // control register bit positions
  localparam int unsigned CTL_MUTE  = 0;
  localparam int unsigned CTL_INV_L = 1;
  localparam int unsigned CTL_INV_R = 2;
  localparam int unsigned CTL_DC    = 3;
  localparam int unsigned CTL_BASS  = 4;
  localparam int unsigned CTL_ROUTE_LO = 5;
  localparam int unsigned CTL_SOLO_LO  = 8;
  localparam int unsigned CTL_W = 10;

  // routing codes; the unused codes behave as stereo
  typedef enum logic [2:0] {
    ROUTE_STEREO,
    ROUTE_SWAP,
    ROUTE_LEFT,
    ROUTE_RIGHT,
    ROUTE_MONO
  } route_t;

  // solo codes; the unused code behaves as off
  typedef enum logic [1:0] {
    SOLO_OFF,
    SOLO_MID,
    SOLO_SIDE
  } solo_t;

  // round half up: add half an lsb, then floor shift
  function automatic wide_t rnd(input wide_t v, input int unsigned s);
    wide_t half;
    half = wide_t'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  // saturate to a signed value of the given width
  function automatic wide_t sat(input wide_t v, input int unsigned bits);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (bits - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

// ----- rtl/stereo_utility_channel_strip.sv -----
// stereo utility channel strip: one shared multiplier under a sequencer
// that steps through gain, routing, balance and mid/side width, then the optional
// bass mono crossover and dc blocker; a new pair is taken only once the
// sequencer is back at idle, after the previous result has been registered;
// a result not yet taken holds the final step
// synchronous active-low reset: configuration registers to defaults, filter state to zero
module stereo_utility_channel_strip (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [sucs_pkg::SAMPLE_W-1:0]  in_left_in,
  input  logic signed [sucs_pkg::SAMPLE_W-1:0]  in_right_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [sucs_pkg::SAMPLE_W-1:0]  out_left_out,
  output logic signed [sucs_pkg::SAMPLE_W-1:0]  out_right_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [2:0]                            cfg_index,
  input  logic [31:0]                           cfg_data
);
  import sucs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_GAIN_L,
    S_GAIN_R,
    S_GAIN_C,
    S_ROUTE,
    S_BAL_L,
    S_BAL_R,
    S_BAL_C,
    S_MS,
    S_WIDTH,
    S_WIDTH_C,
    S_LP_B,
    S_LP_BX,
    S_LP_LOW,
    S_LP_A1,
    S_LP_A2,
    S_LP_Z,
    S_LP_MONO,
    S_LP_MIX,
    S_DC_M,
    S_DC_Y,
    S_DC_O,
    S_DONE
  } state_t;

  state_t state_r;
  logic   ch_r;
  logic   out_valid_r;
  logic signed [SAMPLE_W-1:0] out_left_r;
  logic signed [SAMPLE_W-1:0] out_right_r;

  // configuration registers
  logic [CTL_W-1:0]  ctrl_r;
  logic [23:0]       gain_r;
  logic [22:0]       bal_l_r;
  logic [22:0]       bal_r_r;
  logic [22:0]       width_r;
  logic signed [31:0] b0_r;
  logic signed [31:0] a1_r;
  logic signed [31:0] a2_r;

  // filter state, index 0 left, 1 right
  logic signed [ZW-1:0] z1_r [2];
  logic signed [ZW-1:0] z2_r [2];
  logic signed [IW-1:0] pin_r [2];
  logic signed [LW-1:0] pout_r [2];

  // datapath registers
  logic signed [IW-1:0]   l_r;
  logic signed [IW-1:0]   r_r;
  logic signed [IW-1:0]   mid_r;
  logic signed [IW-1:0]   side_r;
  logic signed [ZW-1:0]   bx_r;
  logic signed [ZW:0]     b1x_r;
  logic signed [LW-1:0]   low_r [2];
  logic signed [LW-1:0]   mono_r;

  // shared multiplier
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod_r;

  logic in_xfer;
  logic out_xfer;
  logic cfg_xfer;

  route_t route;
  solo_t  solo;

  logic signed [IW-1:0] in_l;
  logic signed [IW-1:0] in_r;
  logic signed [IW-1:0] route_l;
  logic signed [IW-1:0] route_r;

  wide_t prod_w;
  wide_t scl20_w;
  wide_t scl22_w;
  wide_t bx_w;
  wide_t b1x_w;
  wide_t fb_w;
  wide_t x_w;
  wide_t low_w;
  wide_t z1n_w;
  wide_t z2n_w;
  wide_t mono_w;
  wide_t mixl_w;
  wide_t mixr_w;
  wide_t dcy_w;
  wide_t dco_w;
  wide_t mid_w;
  wide_t side_w;
  wide_t mid_s_w;
  wide_t side_s_w;
  wide_t sum_w;
  wide_t dif_w;
  wide_t outl_w;
  wide_t outr_w;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid_r && out_ready;
  assign cfg_xfer = cfg_valid && cfg_ready;

  assign route = route_t'(ctrl_r[CTL_ROUTE_LO +: 3]);
  assign solo  = solo_t'(ctrl_r[CTL_SOLO_LO +: 2]);

  sucs_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // multiplier operand select per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_GAIN_L: begin
        mul_a = MUL_AW'(l_r);
        mul_b = $signed(MUL_BW'(gain_r));
      end
      S_GAIN_R: begin
        mul_a = MUL_AW'(r_r);
        mul_b = $signed(MUL_BW'(gain_r));
      end
      S_BAL_L: begin
        mul_a = MUL_AW'(l_r);
        mul_b = $signed(MUL_BW'(bal_l_r));
      end
      S_BAL_R: begin
        mul_a = MUL_AW'(r_r);
        mul_b = $signed(MUL_BW'(bal_r_r));
      end
      S_WIDTH: begin
        mul_a = MUL_AW'(side_r);
        mul_b = $signed(MUL_BW'(width_r));
      end
      S_LP_B: begin
        mul_a = MUL_AW'(ch_r ? r_r : l_r);
        mul_b = MUL_BW'(b0_r);
      end
      S_LP_A1: begin
        mul_a = low_r[ch_r];
        mul_b = MUL_BW'(a1_r);
      end
      S_LP_A2: begin
        mul_a = low_r[ch_r];
        mul_b = MUL_BW'(a2_r);
      end
      S_DC_M: begin
        mul_a = pout_r[ch_r];
        mul_b = MUL_BW'(DC_POLE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // polarity inversion at the input
  assign in_l = ctrl_r[CTL_INV_L] ? -IW'(in_left_in) : IW'(in_left_in);
  assign in_r = ctrl_r[CTL_INV_R] ? -IW'(in_right_in) : IW'(in_right_in);

  // channel routing
  always_comb begin
    route_l = l_r;
    route_r = r_r;
    unique case (route)
      ROUTE_SWAP: begin
        route_l = r_r;
        route_r = l_r;
      end
      ROUTE_LEFT:  route_r = l_r;
      ROUTE_RIGHT: route_l = r_r;
      ROUTE_MONO: begin
        route_l = IW'((wide_t'(l_r) + wide_t'(r_r)) >>> 1);
        route_r = IW'((wide_t'(l_r) + wide_t'(r_r)) >>> 1);
      end
      default: begin
        route_l = l_r;
        route_r = r_r;
      end
    endcase
  end

  // post-multiply scaling, filter and blocker arithmetic
  always_comb begin
    prod_w  = wide_t'(prod_r);
    scl20_w = sat(rnd(prod_w, 20), IW);
    scl22_w = sat(rnd(prod_w, 22), IW);
    bx_w    = rnd(prod_w, 20);
    b1x_w   = rnd(prod_w <<< 1, 20);
    fb_w    = rnd(prod_w, 24);
    x_w     = wide_t'(ch_r ? r_r : l_r);

    // crossover low-pass, transposed direct form two
    low_w = sat(rnd(wide_t'(bx_r) + wide_t'(z1_r[ch_r]), 4), LW);
    z1n_w = sat(wide_t'(b1x_r) - fb_w + wide_t'(z2_r[ch_r]), ZW);
    z2n_w = sat(wide_t'(bx_r) - fb_w, ZW);

    // bass mono mix: highs kept, lows replaced by their mean
    mono_w = (wide_t'(low_r[0]) + wide_t'(low_r[1])) >>> 1;
    mixl_w = sat(rnd(wide_t'(mono_r) + (wide_t'(l_r) <<< 4) - wide_t'(low_r[0]), 4), IW);
    mixr_w = sat(rnd(wide_t'(mono_r) + (wide_t'(r_r) <<< 4) - wide_t'(low_r[1]), 4), IW);

    // dc blocker
    dcy_w = sat(((x_w - wide_t'(pin_r[ch_r])) <<< 4) + rnd(prod_w, 23), LW);
    dco_w = sat(rnd(wide_t'(pout_r[ch_r]), 4), IW);

    // mid/side split and width
    mid_w  = (wide_t'(l_r) + wide_t'(r_r)) >>> 1;
    side_w = (wide_t'(l_r) - wide_t'(r_r)) >>> 1;
    mid_s_w  = wide_t'(mid_r);
    side_s_w = scl20_w;
    unique case (solo)
      SOLO_MID:  side_s_w = '0;
      SOLO_SIDE: mid_s_w  = '0;
      default: begin
        mid_s_w  = wide_t'(mid_r);
        side_s_w = scl20_w;
      end
    endcase
    sum_w = sat(mid_s_w + side_s_w, IW);
    dif_w = sat(mid_s_w - side_s_w, IW);

    // output saturation
    outl_w = sat(wide_t'(l_r), SAMPLE_W);
    outr_w = sat(wide_t'(r_r), SAMPLE_W);
  end

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= '0;
      gain_r  <= 24'd1048576;
      bal_l_r <= 23'd4194304;
      bal_r_r <= 23'd4194304;
      width_r <= 23'd1048576;
      b0_r    <= '0;
      a1_r    <= '0;
      a2_r    <= '0;
    end else if (cfg_xfer) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CONTROL: ctrl_r  <= cfg_data[CTL_W-1:0];
        REG_GAIN:    gain_r  <= cfg_data[23:0];
        REG_BAL_L:   bal_l_r <= cfg_data[22:0];
        REG_BAL_R:   bal_r_r <= cfg_data[22:0];
        REG_WIDTH:   width_r <= cfg_data[22:0];
        REG_LP_B0:   b0_r    <= $signed(cfg_data);
        REG_LP_A1:   a1_r    <= $signed(cfg_data);
        REG_LP_A2:   a2_r    <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // filter state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_r[0]   <= '0;
      z1_r[1]   <= '0;
      z2_r[0]   <= '0;
      z2_r[1]   <= '0;
      pin_r[0]  <= '0;
      pin_r[1]  <= '0;
      pout_r[0] <= '0;
      pout_r[1] <= '0;
    end else begin
      if (state_r == S_LP_A2) begin
        z1_r[ch_r] <= z1n_w[ZW-1:0];
      end
      if (state_r == S_LP_Z) begin
        z2_r[ch_r] <= z2n_w[ZW-1:0];
      end
      if (state_r == S_DC_Y) begin
        pout_r[ch_r] <= dcy_w[LW-1:0];
        pin_r[ch_r]  <= x_w[IW-1:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          l_r <= in_l;
          r_r <= in_r;
        end
      end
      S_GAIN_R:  l_r <= scl20_w[IW-1:0];
      S_GAIN_C:  r_r <= scl20_w[IW-1:0];
      S_ROUTE: begin
        l_r <= route_l;
        r_r <= route_r;
      end
      S_BAL_R:   l_r <= scl22_w[IW-1:0];
      S_BAL_C:   r_r <= scl22_w[IW-1:0];
      S_MS: begin
        mid_r  <= mid_w[IW-1:0];
        side_r <= side_w[IW-1:0];
      end
      S_WIDTH_C: begin
        l_r <= sum_w[IW-1:0];
        r_r <= dif_w[IW-1:0];
      end
      S_LP_BX: begin
        bx_r  <= bx_w[ZW-1:0];
        b1x_r <= b1x_w[ZW:0];
      end
      S_LP_LOW:  low_r[ch_r] <= low_w[LW-1:0];
      S_LP_MONO: mono_r <= mono_w[LW-1:0];
      S_LP_MIX: begin
        l_r <= mixl_w[IW-1:0];
        r_r <= mixr_w[IW-1:0];
      end
      S_DC_O: begin
        if (ch_r) begin
          r_r <= dco_w[IW-1:0];
        end else begin
          l_r <= dco_w[IW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
      out_left_r  <= '0;
      out_right_r <= '0;
    end else begin
      // result valid: raised from the final step, dropped on transfer
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_GAIN_L;
          end
        end
        S_GAIN_L:  state_r <= S_GAIN_R;
        S_GAIN_R:  state_r <= S_GAIN_C;
        S_GAIN_C:  state_r <= S_ROUTE;
        S_ROUTE:   state_r <= S_BAL_L;
        S_BAL_L:   state_r <= S_BAL_R;
        S_BAL_R:   state_r <= S_BAL_C;
        S_BAL_C:   state_r <= S_MS;
        S_MS:      state_r <= S_WIDTH;
        S_WIDTH:   state_r <= S_WIDTH_C;
        S_WIDTH_C: begin
          priority if (ctrl_r[CTL_BASS]) begin
            state_r <= S_LP_B;
          end else if (ctrl_r[CTL_DC]) begin
            state_r <= S_DC_M;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_LP_B:    state_r <= S_LP_BX;
        S_LP_BX:   state_r <= S_LP_LOW;
        S_LP_LOW:  state_r <= S_LP_A1;
        S_LP_A1:   state_r <= S_LP_A2;
        S_LP_A2:   state_r <= S_LP_Z;
        S_LP_Z: begin
          ch_r    <= ~ch_r;
          state_r <= ch_r ? S_LP_MONO : S_LP_B;
        end
        S_LP_MONO: state_r <= S_LP_MIX;
        S_LP_MIX:  state_r <= ctrl_r[CTL_DC] ? S_DC_M : S_DONE;
        S_DC_M:    state_r <= S_DC_Y;
        S_DC_Y:    state_r <= S_DC_O;
        S_DC_O: begin
          ch_r    <= ~ch_r;
          state_r <= ch_r ? S_DONE : S_DC_M;
        end
        S_DONE: begin
          // wait for the output register to free up
          if (!out_valid_r || out_ready) begin
            out_left_r  <= ctrl_r[CTL_MUTE] ? '0 : outl_w[SAMPLE_W-1:0];
            out_right_r <= ctrl_r[CTL_MUTE] ? '0 : outr_w[SAMPLE_W-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input accepted while sequencer busy");

  // a result appears only from the final step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside final step");

  // channel select back at left between items
  a_ch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ch_r)
    else $error("channel select not cleared at idle");

  // mute forces both outputs to zero
  a_mute_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r && ctrl_r[CTL_MUTE])
      |=> (out_left_r == '0 && out_right_r == '0))
    else $error("muted result not zero");
`endif

endmodule

// ----- rtl/sucs_mul.sv -----
// shared signed multiplier with a registered product
// depends on sucs_pkg for operand and product widths
module sucs_mul (
  input  logic                                  clk,
  input  logic signed [sucs_pkg::MUL_AW-1:0]    a,
  input  logic signed [sucs_pkg::MUL_BW-1:0]    b,
  output logic signed [sucs_pkg::MUL_PW-1:0]    prod_r
);
  import sucs_pkg::*;

  logic signed [MUL_PW-1:0] prod_nxt;

  // full-precision product
  assign prod_nxt = MUL_PW'(a) * MUL_PW'(b);

  // product register, one multiply issued per cycle
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for stereo_utility_channel_strip: directed table, then random
// phases, with results checked against a fixed-point channel strip predictor
// depends on rtl/sucs_pkg.sv and rtl/stereo_utility_channel_strip.sv
`timescale 1ns / 1ps

module testbench;
  import sucs_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] FULL_POS = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 24'sh800000;
  localparam logic [31:0] GAIN_UNITY = 32'd1048576;
  localparam logic [31:0] BAL_UNITY = 32'd4194304;
  localparam logic [31:0] WIDTH_UNITY = 32'd1048576;
  localparam logic [31:0] REG23_ALL = 32'h7FFFFF;
  localparam logic [31:0] REG24_ALL = 32'hFFFFFF;
  localparam logic [31:0] COEF_MAX = 32'h7FFFFFFF;
  localparam logic [31:0] COEF_MIN = 32'h80000000;
  // codes with no name in the package
  localparam logic [2:0] ROUTE_UNUSED_HI = 3'd7;
  localparam logic [1:0] SOLO_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1800;
  localparam int MAX_SHOWN = 10;

  // crossover presets: b0, a1, a2 in Q2.28 (about 200 Hz and 1 kHz at 48 kHz)
  localparam int PRESET_B0[2] = '{45150, 1051200};
  localparam int PRESET_A1[2] = '{-526936116, -487298937};
  localparam int PRESET_A2[2] = '{258680511, 223066000};

  typedef struct {
    bit known;
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
  } pair_note_t;

  typedef struct {
    bit is_cfg;
    reg_idx_t idx;
    logic [31:0] data;
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    bit known;
    logic signed [SAMPLE_W-1:0] el;
    logic signed [SAMPLE_W-1:0] er;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_left_in = '0;
  logic signed [SAMPLE_W-1:0] in_right_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_left_out;
  logic signed [SAMPLE_W-1:0] out_right_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_CONTROL;
  logic [31:0] cfg_data = '0;

  // register mirror
  logic [CTL_W-1:0] ctl_set;
  longint gain_set, bal_l_set, bal_r_set, width_set;
  longint b0_set, a1_set, a2_set;
  // filter state mirror
  longint lz1, lz2, rz1, rz2;
  longint dcl_in, dcl_out, dcr_in, dcr_out;

  pair_note_t typed_pairs[$];
  pair_note_t expected_pairs[$];
  plan_row_t plan[$];
  int faults = 0;
  bit calm = 1'b0;

  always #5 clk = ~clk;

  stereo_utility_channel_strip dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // fixed-point helpers
  function automatic longint clip(longint v, int unsigned bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint round_shift(longint v, int unsigned s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic [CTL_W-1:0] ctl_word(bit mute, bit inv_l, bit inv_r, bit dc,
                                                bit bass, logic [2:0] route, logic [1:0] solo);
    logic [CTL_W-1:0] c;
    c = '0;
    c[CTL_MUTE] = mute;
    c[CTL_INV_L] = inv_l;
    c[CTL_INV_R] = inv_r;
    c[CTL_DC] = dc;
    c[CTL_BASS] = bass;
    c[CTL_ROUTE_LO +: 3] = route;
    c[CTL_SOLO_LO +: 2] = solo;
    return c;
  endfunction

  task automatic reset_model();
    ctl_set = '0;
    gain_set = GAIN_UNITY;
    bal_l_set = BAL_UNITY;
    bal_r_set = BAL_UNITY;
    width_set = WIDTH_UNITY;
    b0_set = 0;
    a1_set = 0;
    a2_set = 0;
    lz1 = 0; lz2 = 0; rz1 = 0; rz2 = 0;
    dcl_in = 0; dcl_out = 0; dcr_in = 0; dcr_out = 0;
  endtask

  task automatic apply_reg(logic [2:0] idx, logic [31:0] data);
    int coef;
    coef = data;
    case (reg_idx_t'(idx))
      REG_CONTROL: ctl_set = data[CTL_W-1:0];
      REG_GAIN:    gain_set = longint'(data[23:0]);
      REG_BAL_L:   bal_l_set = longint'(data[22:0]);
      REG_BAL_R:   bal_r_set = longint'(data[22:0]);
      REG_WIDTH:   width_set = longint'(data[22:0]);
      REG_LP_B0:   b0_set = coef;
      REG_LP_A1:   a1_set = coef;
      REG_LP_A2:   a2_set = coef;
      default: ;
    endcase
  endtask

  // one transposed direct-form-II low-pass step, output at filter precision
  task automatic crossover_step(input longint x, inout longint z1, inout longint z2,
                                output longint low);
    longint bx, b1x;
    bx = round_shift(b0_set * x, 20);
    b1x = round_shift(2 * b0_set * x, 20);
    low = clip(round_shift(bx + z1, 4), LW);
    z1 = clip(b1x - round_shift(a1_set * low, 24) + z2, ZW);
    z2 = clip(bx - round_shift(a2_set * low, 24), ZW);
  endtask

  task automatic dc_step(input longint x, inout longint pin, inout longint pout,
                         output longint y_out);
    longint y;
    y = clip((x - pin) * 16 + round_shift(longint'(DC_POLE) * pout, 23), LW);
    pin = x;
    pout = y;
    y_out = clip(round_shift(y, 4), IW);
  endtask

  // full strip: polarity, gain, routing, balance, width and solo, crossover, dc, mute
  task automatic strip_predict(input logic signed [SAMPLE_W-1:0] li, ri,
                               output logic signed [SAMPLE_W-1:0] lo, ro);
    longint l, r, t, mid, side, lowl, lowr, mono;
    l = li;
    r = ri;
    if (ctl_set[CTL_INV_L]) l = -l;
    if (ctl_set[CTL_INV_R]) r = -r;
    l = clip(round_shift(l * gain_set, 20), IW);
    r = clip(round_shift(r * gain_set, 20), IW);
    case (route_t'(ctl_set[CTL_ROUTE_LO +: 3]))
      ROUTE_SWAP: begin
        t = l; l = r; r = t;
      end
      ROUTE_LEFT:  r = l;
      ROUTE_RIGHT: l = r;
      ROUTE_MONO: begin
        t = (l + r) >>> 1; l = t; r = t;
      end
      default: ;
    endcase
    l = clip(round_shift(l * bal_l_set, 22), IW);
    r = clip(round_shift(r * bal_r_set, 22), IW);
    mid = (l + r) >>> 1;
    side = (l - r) >>> 1;
    side = clip(round_shift(side * width_set, 20), IW);
    case (solo_t'(ctl_set[CTL_SOLO_LO +: 2]))
      SOLO_MID:  side = 0;
      SOLO_SIDE: mid = 0;
      default: ;
    endcase
    l = clip(mid + side, IW);
    r = clip(mid - side, IW);
    // lows of both channels replaced by their mean
    if (ctl_set[CTL_BASS]) begin
      crossover_step(l, lz1, lz2, lowl);
      crossover_step(r, rz1, rz2, lowr);
      mono = (lowl + lowr) >>> 1;
      l = clip(round_shift(mono + l * 16 - lowl, 4), IW);
      r = clip(round_shift(mono + r * 16 - lowr, 4), IW);
    end
    if (ctl_set[CTL_DC]) begin
      dc_step(l, dcl_in, dcl_out, l);
      dc_step(r, dcr_in, dcr_out, r);
    end
    if (ctl_set[CTL_MUTE]) begin
      l = 0;
      r = 0;
    end
    lo = SAMPLE_W'(clip(l, SAMPLE_W));
    ro = SAMPLE_W'(clip(r, SAMPLE_W));
  endtask

  task automatic note_fault(string msg);
    faults++;
    if (faults <= MAX_SHOWN) $display("%s", msg);
  endtask

  // transfer monitor: config mirror, prediction and result check
  always @(posedge clk) begin
    pair_note_t note, want;
    logic signed [SAMPLE_W-1:0] pl, pr;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_pairs.size() == 0) begin
          note_fault($sformatf("unexpected result transfer: left %0d right %0d",
                               out_left_out, out_right_out));
        end else begin
          want = expected_pairs.pop_front();
          if (out_left_out !== want.l || out_right_out !== want.r)
            note_fault($sformatf("mismatch: expected left %0d right %0d, got left %0d right %0d",
                                 want.l, want.r, out_left_out, out_right_out));
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        note = typed_pairs.pop_front();
        strip_predict(in_left_in, in_right_in, pl, pr);
        if (note.known) begin
          pl = note.l;
          pr = note.r;
        end
        want.known = 1'b1;
        want.l = pl;
        want.r = pr;
        expected_pairs.push_back(want);
      end
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_pair(logic signed [SAMPLE_W-1:0] l, r, bit known,
                           logic signed [SAMPLE_W-1:0] el, er);
    pair_note_t note;
    note.known = known;
    note.l = el;
    note.r = er;
    typed_pairs.push_back(note);
    in_valid <= 1'b1;
    in_left_in <= l;
    in_right_in <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  endtask

  task automatic drain();
    @(posedge clk);
    while (expected_pairs.size() != 0) @(posedge clk);
  endtask

  function automatic void put_reg(reg_idx_t idx, logic [31:0] data);
    plan_row_t row;
    row = '{idx: REG_CONTROL, default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    plan.push_back(row);
  endfunction

  function automatic void put_pair(logic signed [SAMPLE_W-1:0] l, r);
    plan_row_t row;
    row = '{idx: REG_CONTROL, default: '0};
    row.l = l;
    row.r = r;
    plan.push_back(row);
  endfunction

  function automatic void put_known(logic signed [SAMPLE_W-1:0] l, r, el, er);
    plan_row_t row;
    row = '{idx: REG_CONTROL, default: '0};
    row.l = l;
    row.r = r;
    row.known = 1'b1;
    row.el = el;
    row.er = er;
    plan.push_back(row);
  endfunction

  function automatic void build_plan();
    // defaults after reset: equal channels pass, odd sums floor
    put_known(0, 0, 0, 0);
    put_known(FULL_POS, FULL_POS, FULL_POS, FULL_POS);
    put_known(FULL_NEG, FULL_NEG, FULL_NEG, FULL_NEG);
    put_known(FULL_POS, FULL_NEG, FULL_POS - 1, FULL_NEG);
    put_known(FULL_NEG, FULL_POS, FULL_NEG, FULL_POS);
    put_reg(REG_CONTROL, ctl_word(1, 0, 0, 0, 0, ROUTE_STEREO, SOLO_OFF));
    put_known(FULL_POS, -1, 0, 0);
    // polarity, swap and full gain
    put_reg(REG_CONTROL, ctl_word(0, 1, 1, 0, 0, ROUTE_SWAP, SOLO_OFF));
    put_reg(REG_GAIN, REG24_ALL);
    put_pair(12345, -777);
    put_pair(FULL_NEG, FULL_POS);
    // zero gain silences everything
    put_reg(REG_GAIN, 0);
    put_reg(REG_CONTROL, ctl_word(0, 0, 0, 0, 0, ROUTE_LEFT, SOLO_OFF));
    put_known(FULL_POS, 1000, 0, 0);
    put_reg(REG_GAIN, GAIN_UNITY);
    put_reg(REG_CONTROL, ctl_word(0, 1, 0, 0, 0, ROUTE_LEFT, SOLO_OFF));
    put_pair(-4000, 2500);
    // balance above unity and at zero
    put_reg(REG_CONTROL, ctl_word(0, 0, 0, 0, 0, ROUTE_RIGHT, SOLO_OFF));
    put_reg(REG_BAL_L, REG23_ALL);
    put_reg(REG_BAL_R, 0);
    put_pair(3000000, -3000000);
    put_reg(REG_CONTROL, ctl_word(0, 0, 0, 0, 0, ROUTE_MONO, SOLO_OFF));
    put_pair(FULL_POS, FULL_POS);
    put_pair(FULL_NEG, 1);
    // unused route and solo codes act as stereo and off
    put_reg(REG_CONTROL, ctl_word(0, 0, 0, 0, 0, ROUTE_UNUSED_HI, SOLO_UNUSED));
    put_reg(REG_BAL_L, BAL_UNITY);
    put_reg(REG_BAL_R, BAL_UNITY);
    put_known(-2000000, -2000000, -2000000, -2000000);
    // solo modes with extreme width
    put_reg(REG_CONTROL, ctl_word(0, 0, 0, 0, 0, ROUTE_STEREO, SOLO_MID));
    put_reg(REG_WIDTH, REG23_ALL);
    put_pair(5000000, -1000000);
    put_reg(REG_CONTROL, ctl_word(0, 0, 0, 0, 0, ROUTE_STEREO, SOLO_SIDE));
    put_pair(5000000, -1000000);
    put_reg(REG_WIDTH, 0);
    put_known(7000000, 100, 0, 0);
    // dc blocker step response
    put_reg(REG_WIDTH, WIDTH_UNITY);
    put_reg(REG_CONTROL, ctl_word(0, 0, 0, 1, 0, ROUTE_STEREO, SOLO_OFF));
    put_pair(FULL_POS, FULL_POS);
    put_pair(FULL_POS, FULL_POS);
    put_pair(0, 0);
    // bass mono crossover
    put_reg(REG_LP_B0, PRESET_B0[0]);
    put_reg(REG_LP_A1, PRESET_A1[0]);
    put_reg(REG_LP_A2, PRESET_A2[0]);
    put_reg(REG_CONTROL, ctl_word(0, 0, 0, 0, 1, ROUTE_STEREO, SOLO_OFF));
    put_pair(4000000, -4000000);
    put_pair(4000000, 4000000);
    put_pair(-100, 300);
    // mute while both filters keep running
    put_reg(REG_CONTROL, ctl_word(1, 0, 0, 1, 1, ROUTE_STEREO, SOLO_OFF));
    put_known(FULL_POS, FULL_NEG, 0, 0);
    put_pair(2000000, -1500000);
  endfunction

  function automatic logic [31:0] pick_scale(logic [31:0] unity, logic [31:0] top);
    case ($urandom_range(5))
      0: return unity;
      1: return 0;
      2: return top;
      default: return $urandom_range(0, 4194304);
    endcase
  endfunction

  task automatic setup_phase();
    int k, j;
    logic [31:0] g;
    write_reg(REG_CONTROL, ctl_word($urandom_range(7) == 0, 1'($urandom_range(1)),
                                    1'($urandom_range(1)), 1'($urandom_range(1)),
                                    1'($urandom_range(1)),
                                    3'($urandom_range(7)), 2'($urandom_range(3))));
    if ($urandom_range(1)) begin
      case ($urandom_range(5))
        0: g = GAIN_UNITY;
        1: g = 0;
        2: g = REG24_ALL;
        default: g = $urandom_range(200000, 3000000);
      endcase
      write_reg(REG_GAIN, g);
    end
    if ($urandom_range(1)) write_reg(REG_BAL_L, pick_scale(BAL_UNITY, REG23_ALL));
    if ($urandom_range(1)) write_reg(REG_BAL_R, pick_scale(BAL_UNITY, REG23_ALL));
    if ($urandom_range(1)) write_reg(REG_WIDTH, pick_scale(WIDTH_UNITY, REG23_ALL));
    if ($urandom_range(1)) begin
      k = $urandom_range(5);
      j = $urandom_range(1);
      if (k < 4) begin
        write_reg(REG_LP_B0, PRESET_B0[j] + $urandom_range(0, 2000) - 1000);
        write_reg(REG_LP_A1, PRESET_A1[j]);
        write_reg(REG_LP_A2, PRESET_A2[j]);
      end else if (k == 4) begin
        write_reg(REG_LP_B0, $urandom);
        write_reg(REG_LP_A1, $urandom);
        write_reg(REG_LP_A2, $urandom);
      end else begin
        write_reg(REG_LP_B0, $urandom_range(1) ? COEF_MAX : COEF_MIN);
        write_reg(REG_LP_A1, $urandom_range(1) ? COEF_MAX : COEF_MIN);
        write_reg(REG_LP_A2, $urandom_range(2) == 0 ? 32'd0 : COEF_MIN);
      end
    end
  endtask

  // half of the samples follow a slow random walk so the filters see audio-like input
  function automatic logic signed [SAMPLE_W-1:0] next_sample(inout longint walk);
    int pick, step;
    pick = $urandom_range(19);
    if (pick < 10) begin
      step = int'($urandom_range(65535)) - 32768;
      walk = clip(walk + step, SAMPLE_W);
      return SAMPLE_W'(walk);
    end else if (pick < 15) begin
      return SAMPLE_W'($urandom);
    end else if (pick < 18) begin
      return SAMPLE_W'(int'($urandom_range(8191)) - 4096);
    end
    return $urandom_range(1) ? FULL_POS : FULL_NEG;
  endfunction

  // stimulus
  initial begin
    bit cfg_open;
    int phase, sent, quota;
    longint walk_l, walk_r;
    logic signed [SAMPLE_W-1:0] sl, sr;
    reset_model();
    build_plan();
    cfg_open = 1'b0;
    walk_l = 0;
    walk_r = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed table
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!cfg_open) begin
          in_valid <= 1'b0;
          drain();
        end
        write_reg(plan[i].idx, plan[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid <= 1'b0;
        cfg_open = 1'b0;
        send_pair(plan[i].l, plan[i].r, plan[i].known, plan[i].el, plan[i].er);
        idle_gap();
      end
    end
    // random phases, each under a fresh control word and randomly chosen other register writes
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      in_valid <= 1'b0;
      drain();
      calm = (phase == 3);
      setup_phase();
      cfg_valid <= 1'b0;
      quota = $urandom_range(100, 200);
      if (quota > RANDOM_ITEMS - sent) quota = RANDOM_ITEMS - sent;
      repeat (quota) begin
        sl = next_sample(walk_l);
        sr = next_sample(walk_r);
        send_pair(sl, sr, 1'b0, 0, 0);
        sent++;
        idle_gap();
      end
      phase++;
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    drain();
    repeat (40) @(posedge clk);
    if (faults == 0 && expected_pairs.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sucs_pkg.sv
rtl/sucs_mul.sv
rtl/stereo_utility_channel_strip.sv
verif/testbench.sv
